// File: hw/rtl/sld_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the start-of-message deframer.
// No dependencies; sld_regs, sld_front, sld_queue, sld_back and the top level import this package.
package sld_pkg;

  // Filter modes as held in the filter_mode register; code 3 acts as pass-through.
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_LEN  = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  // Register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_FILTER_MODE   = 3'd0,
    REG_START_PATTERN = 3'd1,
    REG_START_LENGTH  = 3'd2,
    REG_END_PATTERN   = 3'd3,
    REG_END_LENGTH    = 3'd4,
    REG_FRAME_LEN     = 3'd5
  } reg_idx_e;

  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [1:0]  filter_mode;
    logic [31:0] start_pattern;
    logic [2:0]  start_length;
    logic [31:0] end_pattern;
    logic [2:0]  end_length;
    logic [7:0]  frame_len;
  } cfg_t;

  // One queued emit command: 1..4 bytes taken from data, highest lane first.
  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  top_idx;   // lane of the first byte, number of bytes minus one
    logic        last;      // msg_last on the lane 0 byte
  } cmd_t;

endpackage

// File: hw/rtl/sld_rx_if.sv
`timescale 1ns / 1ps
// Received-byte stream channel: valid/ready handshake carrying rx_byte.
// No dependencies.
interface sld_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/sld_msg_if.sv
`timescale 1ns / 1ps
// Message byte stream channel: valid/ready handshake carrying msg_byte, msg_last.
// No dependencies.
interface sld_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       msg_last;

  modport source (output valid, output msg_byte, output msg_last, input ready);
  modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface

// File: hw/rtl/sld_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register file for the deframer.
// Depends on sld_pkg.
module sld_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sld_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output sld_pkg::cfg_t                  cfg_o,
  output logic                           mode_wr_o
);
  import sld_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrWidth-1:2]);

  always_comb begin
    cfg_d     = cfg_q;
    mode_wr_o = 1'b0;
    if (wr_en) begin
      unique case (idx)
        REG_FILTER_MODE: begin
          cfg_d.filter_mode = pwdata[1:0];
          mode_wr_o         = 1'b1;
        end
        REG_START_PATTERN:  cfg_d.start_pattern  = pwdata;
        REG_START_LENGTH:   cfg_d.start_length   = pwdata[2:0];
        REG_END_PATTERN:    cfg_d.end_pattern    = pwdata;
        REG_END_LENGTH:     cfg_d.end_length     = pwdata[2:0];
        REG_FRAME_LEN:      cfg_d.frame_len      = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FILTER_MODE:    prdata = {30'd0, cfg_q.filter_mode};
      REG_START_PATTERN:  prdata = cfg_q.start_pattern;
      REG_START_LENGTH:   prdata = {29'd0, cfg_q.start_length};
      REG_END_PATTERN:    prdata = cfg_q.end_pattern;
      REG_END_LENGTH:     prdata = {29'd0, cfg_q.end_length};
      REG_FRAME_LEN:      prdata = {24'd0, cfg_q.frame_len};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mode   <= MODE_PASS;
      cfg_q.start_pattern <= 32'd0;
      cfg_q.start_length  <= 3'd1;
      cfg_q.end_pattern   <= 32'd0;
      cfg_q.end_length    <= 3'd1;
      cfg_q.frame_len     <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/sld_front.sv
`timescale 1ns / 1ps
// Front end: accepts received bytes, tracks pattern history and message
// state, and turns each byte into zero or one emit command. Depends on sld_pkg.
module sld_front #(
  parameter int unsigned MAX_PATTERN_BYTES = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sld_pkg::cfg_t cfg_i,
  input  logic          mode_wr_i,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  output logic          in_ready_o,
  input  logic          q_full_i,
  output logic          push_o,
  output sld_pkg::cmd_t cmd_o
);
  import sld_pkg::*;

  localparam int unsigned Cap = (MAX_PATTERN_BYTES < 4) ? MAX_PATTERN_BYTES : 4;
  localparam int unsigned HW  = 8 * Cap;
  localparam int unsigned CW  = $clog2(Cap + 1);

  logic [HW-1:0]   hist_q, hist_d, hist_next;
  logic [HW+7:0]   hist_wide;
  logic [CW-1:0]   cnt_q, cnt_d, cnt_next;
  logic            in_msg_q, in_msg_d;
  logic [7:0]      mc_q, mc_d, mc_inc;
  logic [2:0]      sl, el;
  logic [7:0]      total;
  logic            accept, filt, start_hit, end_hit, last, short_msg;

  // Clamp a pattern length to 1..Cap
  function automatic logic [2:0] eff_len(input logic [2:0] n);
    logic [2:0] r;
    if (n == 3'd0) r = 3'd1;
    else if (n > 3'(Cap)) r = 3'(Cap);
    else r = n;
    return r;
  endfunction

  function automatic logic tail_hit(input logic [HW-1:0] h, input logic [CW-1:0] c,
                                    input logic [31:0] pat, input logic [2:0] n);
    logic ok;
    ok = ({{(8-CW){1'b0}}, c} >= {5'd0, n});
    for (int j = 0; j < Cap; j++) begin
      if (3'(j) < n && h[8*j +: 8] != pat[8*j +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  assign sl        = eff_len(cfg_i.start_length);
  assign el        = eff_len(cfg_i.end_length);
  assign total     = (cfg_i.frame_len < {5'd0, sl}) ? {5'd0, sl} : cfg_i.frame_len;
  assign filt      = (cfg_i.filter_mode == MODE_LEN) || (cfg_i.filter_mode == MODE_END);
  assign hist_wide = {hist_q, in_byte_i};
  assign hist_next = hist_wide[HW-1:0];
  assign cnt_next  = (cnt_q == CW'(Cap)) ? cnt_q : cnt_q + 1'b1;
  assign mc_inc    = (mc_q == 8'hFF) ? mc_q : mc_q + 8'd1;
  assign start_hit = tail_hit(hist_next, cnt_next, cfg_i.start_pattern, sl);
  assign end_hit   = tail_hit(hist_next, cnt_next, cfg_i.end_pattern, el);
  assign short_msg = (cfg_i.filter_mode == MODE_LEN) && (total == {5'd0, sl});

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hist_d       = hist_q;
    cnt_d        = cnt_q;
    in_msg_d     = in_msg_q;
    mc_d         = mc_q;
    push_o       = 1'b0;
    last         = 1'b0;
    cmd_o.data   = {24'd0, in_byte_i};
    cmd_o.top_idx = 2'd0;
    cmd_o.last   = 1'b0;
    if (mode_wr_i) begin
      in_msg_d = 1'b0;
      cnt_d    = '0;
      mc_d     = 8'd0;
    end else if (accept) begin
      priority if (!filt) begin
        push_o = 1'b1;
      end else if (in_msg_q) begin
        mc_d = mc_inc;
        if (cfg_i.filter_mode == MODE_LEN) begin
          last = (mc_inc >= total);
        end else begin
          hist_d = hist_next;
          cnt_d  = cnt_next;
          last   = end_hit;
        end
        push_o     = 1'b1;
        cmd_o.last = last;
        if (last) begin
          in_msg_d = 1'b0;
          cnt_d    = '0;
          mc_d     = 8'd0;
        end
      end else begin
        hist_d = hist_next;
        cnt_d  = cnt_next;
        if (start_hit) begin
          push_o             = 1'b1;
          cmd_o.data         = 32'd0;
          cmd_o.data[HW-1:0] = hist_next;
          cmd_o.top_idx      = 2'(sl - 3'd1);
          cmd_o.last         = short_msg;
          cnt_d              = '0;
          in_msg_d           = !short_msg;
          mc_d               = short_msg ? 8'd0 : {5'd0, sl};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= '0;
      cnt_q    <= '0;
      in_msg_q <= 1'b0;
      mc_q     <= 8'd0;
    end else begin
      hist_q   <= hist_d;
      cnt_q    <= cnt_d;
      in_msg_q <= in_msg_d;
      mc_q     <= mc_d;
    end
  end

endmodule

// File: hw/rtl/sld_queue.sv
`timescale 1ns / 1ps
// Small command queue between the front and back ends.
// Depends on sld_pkg.
module sld_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sld_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sld_pkg::cmd_t cmd_o
);
  import sld_pkg::*;

  localparam int unsigned PW = $clog2(QueueDepth);

  cmd_t          mem_q [QueueDepth];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/sld_back.sv
`timescale 1ns / 1ps
// Back end: takes commands from the queue and emits their bytes one per
// transfer, highest lane first, from a held output register. Depends on sld_pkg.
module sld_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  sld_pkg::cmd_t q_cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);
  import sld_pkg::*;

  cmd_t       cur_q, cur_d;
  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic       xfer, done;

  assign xfer  = vld_q && out_ready_i;
  assign done  = xfer && (idx_q == 2'd0);
  assign pop_o = (!vld_q || done) && !q_empty_i;

  always_comb begin
    cur_d = cur_q;
    idx_d = idx_q;
    vld_d = vld_q;
    if (pop_o) begin
      cur_d = q_cmd_i;
      idx_d = q_cmd_i.top_idx;
      vld_d = 1'b1;
    end else if (done) begin
      vld_d = 1'b0;
    end else if (xfer) begin
      idx_d = idx_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = cur_q.data[{idx_q, 3'b000} +: 8];
  assign out_last_o  = cur_q.last && (idx_q == 2'd0);

endmodule

// File: hw/rtl/som_length_eom_deframer_unit.sv
`timescale 1ns / 1ps
// Deframer top level; depends on sld_pkg, sld_rx_if, sld_msg_if, sld_regs, sld_front,
// sld_queue, sld_back. An accepted byte is written into the command queue, then loaded
// into the output register, and transfers on msg from there. Throughput, while msg.ready
// is high: one byte per cycle; the 1..4 bytes of a start match go out one per cycle
// while a four-entry command queue holds later bytes; rx.ready drops when it is full.
// Reset (rst_ni low, async): idle, empty queue, registers at reset values.
module som_length_eom_deframer_unit #(
  parameter int unsigned MAX_PATTERN_BYTES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sld_rx_if.sink                        rx,
  sld_msg_if.source                     msg,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sld_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sld_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic mode_wr, q_full, q_empty, push, pop;

  sld_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o     (cfg),
    .mode_wr_o (mode_wr)
  );

  sld_front #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_front (
    .clk_i, .rst_ni,
    .cfg_i      (cfg),
    .mode_wr_i  (mode_wr),
    .in_valid_i (rx.valid),
    .in_byte_i  (rx.rx_byte),
    .in_ready_o (rx.ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  sld_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  sld_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .pop_o       (pop),
    .out_valid_o (msg.valid),
    .out_ready_i (msg.ready),
    .out_byte_o  (msg.msg_byte),
    .out_last_o  (msg.msg_last)
  );

endmodule
